@@ sv/pbew_pkg.sv @@
// Package for the PCI bus enumeration walker: payload types and constants.
// Depends on nothing; used by all modules and the bench.
package pbew_pkg;

   typedef enum logic [1:0] {
      KIND_REQUEST = 2'd0,
      KIND_RECORD  = 2'd1,
      KIND_FINISH  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      STAT_SUCCESS  = 2'd0,
      STAT_FULL     = 2'd1,
      STAT_TOO_DEEP = 2'd2
   } status_type;

   localparam logic OP_START = 1'b0;
   localparam logic OP_DATA  = 1'b1;

   localparam logic [7:0] REG_VENDOR  = 8'h00;
   localparam logic [7:0] REG_CLASS   = 8'h08;
   localparam logic [7:0] REG_HEADER  = 8'h0c;
   localparam logic [7:0] REG_BUSNUM  = 8'h18;
   localparam logic [15:0] VID_NONE   = 16'hffff;
   localparam logic [7:0] CLASS_BRIDGE = 8'h06;
   localparam logic [7:0] SUB_PCI_PCI  = 8'h04;

   typedef struct packed {
      logic       operation;
      logic [31:0] read_data;
   } req_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [31:0] cfg_address;
      logic [7:0]  bus_number;
      logic [4:0]  slot_number;
      logic [2:0]  function_number;
      logic [7:0]  header_kind;
      logic [7:0]  class_base;
      logic [7:0]  class_sub;
      logic [7:0]  class_prog_if;
      logic [5:0]  found_count;
      logic        last;
   } rsp_type;

   // Datapath commands from the controller.
   typedef enum logic [3:0] {
      DP_NONE,
      DP_START,       // clear counters and position
      DP_SET_BUS,     // bus <= value, slot/fn <= 0
      DP_SET_FN_HOST, // bus <= bus+1 (host function walk)
      DP_SAVE_CLASS,
      DP_INC_FN,
      DP_INC_SLOT,
      DP_POP,
      DP_PUSH_BUS,    // push position then begin secondary bus
      DP_COUNT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [7:0] bus_value;
   } dp_cmd_type;

   typedef struct packed {
      logic [7:0] bus;
      logic [4:0] slot;
      logic [2:0] fn;
      logic [23:0] cls;
      logic        stack_empty;
      logic        stack_full;
      logic        table_full;
      logic [5:0]  total;
   } dp_stat_type;

endpackage

@@ sv/pbew_if.sv @@
// Valid/ready channel interface carrying one payload beat.
// Depends on nothing.
interface pbew_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

@@ sv/pci_bus_enumeration_walker.sv @@
// PCI bus enumeration walker, top level: controller plus datapath.
// A beat is registered on acceptance and decoded in ST_DECODE, and its first result is registered;
// each internal walk step (function done, next function, next slot, bus done or pop) adds a state.
// A new beat is taken only once the walk steps are through and all results have drained.
// Reset: synchronous, active high; walk returns to idle, stack contents undefined.
// Depends on pbew_pkg, pbew_if, pbew_control, pbew_datapath.
module pci_bus_enumeration_walker #(
   parameter int MAX_DEVICES = 32,
   parameter int MAX_NEST    = 8
) (
   input logic clock,
   input logic reset,
   pbew_if.sink   req,
   pbew_if.source rsp
);
   import pbew_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;
   logic [23:0] cls;

   // Controller: phase machine, result staging (record then request or finish).
   pbew_control u_ctl (
      .clock, .reset,
      .req_valid(req.valid), .req_ready(req.ready), .req_data(req.data),
      .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_data(rsp.data),
      .cmd, .class_out(cls), .stat
   );

   // Datapath: position, class, counter and return stack.
   pbew_datapath #(.MAX_DEVICES(MAX_DEVICES), .MAX_NEST(MAX_NEST)) u_dp (
      .clock, .reset, .cmd, .class_in(cls), .stat
   );
endmodule

@@ sv/pbew_datapath.sv @@
// Walk position registers, saved class, device counter and return stack.
// Depends on pbew_pkg.
module pbew_datapath #(
   parameter int MAX_DEVICES = 32,
   parameter int MAX_NEST    = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  pbew_pkg::dp_cmd_type cmd,
   input  logic [23:0]         class_in,
   output pbew_pkg::dp_stat_type stat
);
   import pbew_pkg::*;

   localparam int SpW = $clog2(MAX_NEST + 1);
   localparam int IdxW = (MAX_NEST > 1) ? $clog2(MAX_NEST) : 1;

   logic [7:0]  bus_ff, bus_in;
   logic [4:0]  slot_ff, slot_in;
   logic [2:0]  fn_ff, fn_in;
   logic [23:0] cls_ff, cls_in;
   logic [SpW-1:0] sp_ff, sp_in;
   logic [5:0]  total_ff, total_in;
   logic [15:0] stack_ff [MAX_NEST];
   logic [15:0] top;
   logic [IdxW-1:0] wr_idx, rd_idx;
   logic [SpW-1:0] sp_dec;

   assign sp_dec = sp_ff - SpW'(1);
   assign wr_idx = IdxW'(sp_ff);
   assign rd_idx = IdxW'(sp_dec);
   assign top    = stack_ff[rd_idx];

   always_comb begin
      bus_in = bus_ff; slot_in = slot_ff; fn_in = fn_ff;
      cls_in = cls_ff; sp_in = sp_ff; total_in = total_ff;
      case (cmd.op)
         DP_START: begin
            bus_in = '0; slot_in = '0; fn_in = '0; sp_in = '0; total_in = '0;
         end
         DP_SET_BUS: begin
            bus_in = cmd.bus_value; slot_in = '0; fn_in = '0;
         end
         DP_SET_FN_HOST: bus_in = bus_ff + 8'd1;
         DP_SAVE_CLASS:  cls_in = class_in;
         DP_INC_FN:      fn_in = fn_ff + 3'd1;
         DP_INC_SLOT: begin
            slot_in = slot_ff + 5'd1; fn_in = '0;
         end
         DP_POP: begin
            sp_in = sp_dec; bus_in = top[15:8]; slot_in = top[7:3]; fn_in = top[2:0];
         end
         DP_PUSH_BUS: begin
            sp_in = sp_ff + SpW'(1);
            bus_in = cmd.bus_value; slot_in = '0; fn_in = '0;
         end
         DP_COUNT:       total_in = total_ff + 6'd1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bus_ff <= '0; slot_ff <= '0; fn_ff <= '0; cls_ff <= '0;
         sp_ff <= '0; total_ff <= '0;
      end else begin
         bus_ff <= bus_in; slot_ff <= slot_in; fn_ff <= fn_in; cls_ff <= cls_in;
         sp_ff <= sp_in; total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_PUSH_BUS) begin
         stack_ff[wr_idx] <= {bus_ff, slot_ff, fn_ff};
      end
   end

   assign stat.bus = bus_ff;
   assign stat.slot = slot_ff;
   assign stat.fn = fn_ff;
   assign stat.cls = cls_ff;
   assign stat.stack_empty = (sp_ff == '0);
   assign stat.stack_full = (32'(sp_ff) >= MAX_NEST);
   assign stat.table_full = (32'(total_ff) >= MAX_DEVICES);
   assign stat.total = total_ff;
endmodule

@@ sv/pbew_control.sv @@
// Walk sequencer: decodes each beat, drives datapath commands and emits results.
// Depends on pbew_pkg.
module pbew_control (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  pbew_pkg::req_type     req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output pbew_pkg::rsp_type     rsp_data,
   output pbew_pkg::dp_cmd_type  cmd,
   output logic [23:0]           class_out,
   input  pbew_pkg::dp_stat_type stat
);
   import pbew_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE, PH_HOST_HDR, PH_HOST_VID, PH_BUS_VID, PH_CLASS, PH_HDR,
      PH_DEV_HDR0, PH_FUNC_VID, PH_BUSNUM
   } phase_type;

   typedef enum logic [2:0] {
      ST_WAIT, ST_DECODE, ST_FUNC_DONE, ST_NEXT_FN, ST_DEV_DONE, ST_BUS_DONE,
      ST_HOST_NEXT
   } state_type;

   state_type  st_ff;
   phase_type  ph_ff;
   logic       multi_ff;
   logic       op_ff;
   logic [31:0] data_ff;
   logic       rv_ff;
   rsp_type    rsp_ff;
   logic       pend_ff;
   rsp_type    pend_data_ff;

   // Output register plus one pending slot: at most two results per beat.
   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;
   assign req_ready = (st_ff == ST_WAIT) && !pend_ff && !rv_ff;
   assign class_out = data_ff[31:8];

   function automatic rsp_type mk_req(logic [7:0] b, logic [4:0] s, logic [2:0] f,
                                      logic [7:0] r, logic [5:0] n);
      rsp_type o;
      o = '0;
      o.kind = KIND_REQUEST;
      o.cfg_address = {1'b1, 7'd0, b, s, f, r & 8'hfc};
      o.found_count = n;
      o.last = 1'b1;
      return o;
   endfunction

   function automatic rsp_type mk_fin(status_type st, logic [5:0] n);
      rsp_type o;
      o = '0;
      o.kind = KIND_FINISH;
      o.status = st;
      o.found_count = n;
      o.last = 1'b1;
      return o;
   endfunction

   state_type  st_in;
   phase_type  ph_in;
   logic       multi_in;
   logic       emit;
   rsp_type    emit_data;
   logic       rec;
   rsp_type    rec_data;
   logic       take;
   logic       rv_in;
   rsp_type    rsp_in;
   logic       pend_in;
   rsp_type    pend_data_in;

   assign take = req_valid && req_ready;

   always_comb begin
      st_in = st_ff; ph_in = ph_ff; multi_in = multi_ff;
      emit = 1'b0; emit_data = '0; rec = 1'b0; rec_data = '0;
      cmd.op = DP_NONE; cmd.bus_value = '0;
      case (st_ff)
         ST_WAIT: if (take) st_in = ST_DECODE;
         ST_DECODE: begin
            st_in = ST_WAIT;
            if (op_ff == OP_START) begin
               cmd.op = DP_START; multi_in = 1'b0;
               emit = 1'b1; emit_data = mk_req(8'd0, 5'd0, 3'd0, REG_HEADER, 6'd0);
               ph_in = PH_HOST_HDR;
            end else begin
               case (ph_ff)
                  PH_HOST_HDR: begin
                     cmd.op = DP_SET_BUS; cmd.bus_value = 8'd0;
                     emit = 1'b1;
                     if (!data_ff[23]) begin
                        multi_in = 1'b0; ph_in = PH_BUS_VID;
                     end else begin
                        multi_in = 1'b1; ph_in = PH_HOST_VID;
                     end
                     emit_data = mk_req(8'd0, 5'd0, 3'd0, REG_VENDOR, stat.total);
                  end
                  PH_HOST_VID: begin
                     if (data_ff[15:0] == VID_NONE) st_in = ST_HOST_NEXT;
                     else begin
                        cmd.op = DP_SET_BUS; cmd.bus_value = stat.bus;
                        emit = 1'b1; ph_in = PH_BUS_VID;
                        emit_data = mk_req(stat.bus, 5'd0, 3'd0, REG_VENDOR, stat.total);
                     end
                  end
                  PH_BUS_VID, PH_FUNC_VID: begin
                     if (data_ff[15:0] == VID_NONE)
                        st_in = (ph_ff == PH_BUS_VID) ? ST_DEV_DONE : ST_NEXT_FN;
                     else begin
                        emit = 1'b1; ph_in = PH_CLASS;
                        emit_data = mk_req(stat.bus, stat.slot,
                           (ph_ff == PH_BUS_VID) ? 3'd0 : stat.fn, REG_CLASS, stat.total);
                     end
                  end
                  PH_CLASS: begin
                     cmd.op = DP_SAVE_CLASS; emit = 1'b1; ph_in = PH_HDR;
                     emit_data = mk_req(stat.bus, stat.slot, stat.fn, REG_HEADER,
                                        stat.total);
                  end
                  PH_HDR: begin
                     if (stat.table_full) begin
                        emit = 1'b1; emit_data = mk_fin(STAT_FULL, stat.total);
                        ph_in = PH_IDLE;
                     end else begin
                        cmd.op = DP_COUNT;
                        rec = 1'b1;
                        rec_data = '0;
                        rec_data.kind = KIND_RECORD;
                        rec_data.bus_number = stat.bus;
                        rec_data.slot_number = stat.slot;
                        rec_data.function_number = stat.fn;
                        rec_data.header_kind = data_ff[23:16];
                        rec_data.class_base = stat.cls[23:16];
                        rec_data.class_sub = stat.cls[15:8];
                        rec_data.class_prog_if = stat.cls[7:0];
                        rec_data.found_count = stat.total + 6'd1;
                        if (stat.cls[23:16] == CLASS_BRIDGE &&
                            stat.cls[15:8] == SUB_PCI_PCI) begin
                           emit = 1'b1; ph_in = PH_BUSNUM;
                           emit_data = mk_req(stat.bus, stat.slot, stat.fn, REG_BUSNUM,
                                              stat.total + 6'd1);
                        end else begin
                           st_in = ST_FUNC_DONE;
                        end
                     end
                  end
                  PH_DEV_HDR0: st_in = data_ff[23] ? ST_NEXT_FN : ST_DEV_DONE;
                  PH_BUSNUM: begin
                     emit = 1'b1;
                     if (stat.stack_full) begin
                        emit_data = mk_fin(STAT_TOO_DEEP, stat.total); ph_in = PH_IDLE;
                     end else begin
                        cmd.op = DP_PUSH_BUS; cmd.bus_value = data_ff[15:8];
                        ph_in = PH_BUS_VID;
                        emit_data = mk_req(data_ff[15:8], 5'd0, 3'd0, REG_VENDOR,
                                           stat.total);
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_FUNC_DONE: begin
            if (stat.fn == 3'd0) begin
               emit = 1'b1; ph_in = PH_DEV_HDR0; st_in = ST_WAIT;
               emit_data = mk_req(stat.bus, stat.slot, 3'd0, REG_HEADER, stat.total);
            end else st_in = ST_NEXT_FN;
         end
         ST_NEXT_FN: begin
            if (stat.fn != 3'd7) begin
               cmd.op = DP_INC_FN; emit = 1'b1; ph_in = PH_FUNC_VID; st_in = ST_WAIT;
               emit_data = mk_req(stat.bus, stat.slot, stat.fn + 3'd1, REG_VENDOR,
                                  stat.total);
            end else st_in = ST_DEV_DONE;
         end
         ST_DEV_DONE: begin
            if (stat.slot != 5'd31) begin
               cmd.op = DP_INC_SLOT; emit = 1'b1; ph_in = PH_BUS_VID; st_in = ST_WAIT;
               emit_data = mk_req(stat.bus, stat.slot + 5'd1, 3'd0, REG_VENDOR,
                                  stat.total);
            end else st_in = ST_BUS_DONE;
         end
         ST_BUS_DONE: begin
            if (!stat.stack_empty) begin
               cmd.op = DP_POP; st_in = ST_FUNC_DONE;
            end else if (multi_ff) st_in = ST_HOST_NEXT;
            else begin
               emit = 1'b1; emit_data = mk_fin(STAT_SUCCESS, stat.total);
               ph_in = PH_IDLE; st_in = ST_WAIT;
            end
         end
         ST_HOST_NEXT: begin
            st_in = ST_WAIT; emit = 1'b1;
            if (stat.bus < 8'd7) begin
               cmd.op = DP_SET_FN_HOST; ph_in = PH_HOST_VID;
               emit_data = mk_req(8'd0, 5'd0, stat.bus[2:0] + 3'd1, REG_VENDOR,
                                  stat.total);
            end else begin
               emit_data = mk_fin(STAT_SUCCESS, stat.total); ph_in = PH_IDLE;
            end
         end
         default: st_in = ST_WAIT;
      endcase
   end

   // Result staging: record goes first; a following result waits in the pending slot.
   always_comb begin
      rv_in = rv_ff; rsp_in = rsp_ff; pend_in = pend_ff; pend_data_in = pend_data_ff;
      if (rv_ff && rsp_ready) begin
         rv_in = pend_ff; rsp_in = pend_data_ff; pend_in = 1'b0;
      end
      if (rec) begin
         rv_in = 1'b1; rsp_in = rec_data;
         rsp_in.last = !(emit || st_in != ST_WAIT);
      end
      if (emit) begin
         if (rec || (rv_ff && !rsp_ready) || pend_ff) begin
            pend_in = 1'b1; pend_data_in = emit_data;
         end else begin
            rv_in = 1'b1; rsp_in = emit_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_WAIT; ph_ff <= PH_IDLE; multi_ff <= 1'b0;
         rv_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         st_ff <= st_in; ph_ff <= ph_in; multi_ff <= multi_in;
         rv_ff <= rv_in; rsp_ff <= rsp_in;
         pend_ff <= pend_in; pend_data_ff <= pend_data_in;
      end
   end

   // A record from the current beat is completed by the result that follows
   // (request or finish); if none follows, the record itself is last.
   always_ff @(posedge clock) begin
      if (take) begin
         op_ff <= req_data.operation; data_ff <= req_data.read_data;
      end
   end
endmodule

@@ tb/tb.sv @@
// Self-checking bench for pci_bus_enumeration_walker: answers the walker's config
// reads with random topologies and checks every result beat against a predictor.
// Depends on pbew_pkg, pbew_if and the walker RTL.
module tb;
   import pbew_pkg::*;

   typedef enum int {
      WK_IDLE, WK_HOST_HDR, WK_HOST_VID, WK_BUS_VID, WK_CLASS,
      WK_HDR, WK_DEV_HDR0, WK_FUNC_VID, WK_BUSNUM
   } walk_phase_type;

   typedef enum int {
      STEP_FUNC_DONE, STEP_NEXT_FN, STEP_DEV_DONE, STEP_BUS_DONE
   } step_type;

   localparam int DEVICE_LIMIT = 32;
   localparam int NEST_LIMIT   = 8;

   // Predictor of the walk plus queue of the result beats still owed by the block.
   class walk_scoreboard;
      bit [7:0]    cur_bus;
      bit [4:0]    cur_slot;
      bit [2:0]    cur_fn;
      walk_phase_type phase;
      bit          host_multi;
      bit [23:0]   saved_cls;
      int          depth;
      int          total;
      bit [15:0]   frames [NEST_LIMIT];
      rsp_type     owed [$];
      rsp_type     step_beats [$];
      int          errors;

      function new();
         phase = WK_IDLE;
      endfunction

      function void push_beat(kind_type k, status_type s, bit [31:0] a, bit [7:0] b,
                              bit [4:0] sl, bit [2:0] f, bit [7:0] h, bit [23:0] c);
         rsp_type r;
         r = '0;
         r.kind = k;
         r.status = s;
         r.cfg_address = a;
         r.bus_number = b;
         r.slot_number = sl;
         r.function_number = f;
         r.header_kind = h;
         r.class_base = c[23:16];
         r.class_sub = c[15:8];
         r.class_prog_if = c[7:0];
         r.found_count = total[5:0];
         step_beats.push_back(r);
      endfunction

      function void read_req(bit [7:0] b, bit [4:0] sl, bit [2:0] f, bit [7:0] rg,
                             walk_phase_type nxt);
         push_beat(KIND_REQUEST, STAT_SUCCESS,
                   {1'b1, 7'd0, b, sl, f, rg & 8'hfc}, 0, 0, 0, 0, 0);
         phase = nxt;
      endfunction

      function void done(status_type s);
         push_beat(KIND_FINISH, s, 0, 0, 0, 0, 0, 0);
         phase = WK_IDLE;
      endfunction

      function void enter_bus(bit [7:0] b);
         cur_bus = b;
         cur_slot = 0;
         cur_fn = 0;
         read_req(b, 0, 0, REG_VENDOR, WK_BUS_VID);
      endfunction

      function void advance(step_type s);
         forever begin
            case (s)
               STEP_FUNC_DONE: begin
                  if (cur_fn == 0) begin
                     read_req(cur_bus, cur_slot, 0, REG_HEADER, WK_DEV_HDR0);
                     return;
                  end
                  s = STEP_NEXT_FN;
               end
               STEP_NEXT_FN: begin
                  if (cur_fn < 7) begin
                     cur_fn++;
                     read_req(cur_bus, cur_slot, cur_fn, REG_VENDOR, WK_FUNC_VID);
                     return;
                  end
                  s = STEP_DEV_DONE;
               end
               STEP_DEV_DONE: begin
                  if (cur_slot < 31) begin
                     cur_slot++;
                     cur_fn = 0;
                     read_req(cur_bus, cur_slot, 0, REG_VENDOR, WK_BUS_VID);
                     return;
                  end
                  s = STEP_BUS_DONE;
               end
               default: begin
                  if (depth > 0) begin
                     depth--;
                     {cur_bus, cur_slot, cur_fn} = frames[depth];
                     s = STEP_FUNC_DONE;
                  end else begin
                     // top level: the bus number doubles as the host function
                     if (host_multi && cur_bus < 7) begin
                        cur_bus++;
                        read_req(0, 0, cur_bus[2:0], REG_VENDOR, WK_HOST_VID);
                     end else begin
                        done(STAT_SUCCESS);
                     end
                     return;
                  end
               end
            endcase
         end
      endfunction

      // Note one accepted input beat and queue what it should produce.
      function void note_input(req_type q);
         bit [15:0] vid;
         bit [7:0]  hdr;
         vid = q.read_data[15:0];
         hdr = q.read_data[23:16];
         step_beats.delete();
         if (q.operation == OP_START) begin
            total = 0;
            depth = 0;
            host_multi = 0;
            cur_bus = 0;
            cur_slot = 0;
            cur_fn = 0;
            read_req(0, 0, 0, REG_HEADER, WK_HOST_HDR);
         end else begin
            case (phase)
               WK_HOST_HDR:
                  if (!hdr[7]) begin
                     host_multi = 0;
                     enter_bus(0);
                  end else begin
                     host_multi = 1;
                     cur_bus = 0;
                     read_req(0, 0, 0, REG_VENDOR, WK_HOST_VID);
                  end
               WK_HOST_VID:
                  if (vid == VID_NONE) begin
                     if (cur_bus < 7) begin
                        cur_bus++;
                        read_req(0, 0, cur_bus[2:0], REG_VENDOR, WK_HOST_VID);
                     end else begin
                        done(STAT_SUCCESS);
                     end
                  end else begin
                     enter_bus(cur_bus);
                  end
               WK_BUS_VID:
                  if (vid == VID_NONE) advance(STEP_DEV_DONE);
                  else read_req(cur_bus, cur_slot, 0, REG_CLASS, WK_CLASS);
               WK_FUNC_VID:
                  if (vid == VID_NONE) advance(STEP_NEXT_FN);
                  else read_req(cur_bus, cur_slot, cur_fn, REG_CLASS, WK_CLASS);
               WK_CLASS: begin
                  saved_cls = q.read_data[31:8];
                  read_req(cur_bus, cur_slot, cur_fn, REG_HEADER, WK_HDR);
               end
               WK_HDR:
                  if (total >= DEVICE_LIMIT) begin
                     done(STAT_FULL);
                  end else begin
                     total++;
                     push_beat(KIND_RECORD, STAT_SUCCESS, 0, cur_bus, cur_slot, cur_fn,
                               hdr, saved_cls);
                     if (saved_cls[23:16] == CLASS_BRIDGE && saved_cls[15:8] == SUB_PCI_PCI)
                        read_req(cur_bus, cur_slot, cur_fn, REG_BUSNUM, WK_BUSNUM);
                     else
                        advance(STEP_FUNC_DONE);
                  end
               WK_DEV_HDR0:
                  if (!hdr[7]) advance(STEP_DEV_DONE);
                  else advance(STEP_NEXT_FN);
               WK_BUSNUM:
                  if (depth >= NEST_LIMIT) begin
                     done(STAT_TOO_DEEP);
                  end else begin
                     frames[depth] = {cur_bus, cur_slot, cur_fn};
                     depth++;
                     enter_bus(q.read_data[15:8]);
                  end
               default: ;
            endcase
         end
         if (step_beats.size() > 0) step_beats[step_beats.size() - 1].last = 1'b1;
         foreach (step_beats[i]) owed.push_back(step_beats[i]);
      endfunction

      // Compare one accepted result beat with the oldest owed one.
      function void check_result(rsp_type got);
         rsp_type want;
         if (owed.size() == 0) begin
            errors++;
            if (errors <= 10) $display("ERROR: unexpected result beat %p", got);
            return;
         end
         want = owed.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10) $display("ERROR: result mismatch\n  expected %p\n  actual   %p",
                                       want, got);
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   pbew_if #(.payload_type(req_type)) req_ch (clock);
   pbew_if #(.payload_type(rsp_type)) rsp_ch (clock);

   pci_bus_enumeration_walker #(.MAX_DEVICES(DEVICE_LIMIT), .MAX_NEST(NEST_LIMIT)) dut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   walk_scoreboard sb = new();
   int send_idle_pct;
   int recv_idle_pct;
   bit deep_scan;   // bridge-heavy topology, to push nesting to its limit

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Receiver: random back-pressure per the current phase.
   initial rsp_ch.ready = 1'b0;
   always @(posedge clock) begin
      rsp_ch.ready <= (reset == 1'b0) && ($urandom_range(99) >= recv_idle_pct);
   end

   // Result monitor: sampled at the edge, before any driver update lands.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) sb.check_result(rsp_ch.data);
   end

   // Hold a beat on the request channel until accepted; idle gaps in between.
   task automatic send_beat(logic op, logic [31:0] data);
      req_type q;
      q.operation = op;
      q.read_data = data;
      req_ch.valid <= 1'b1;
      req_ch.data <= q;
      do @(posedge clock); while (!req_ch.ready);
      sb.note_input(q);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
   endtask

   // Answer the read the walker is waiting on, with a random device population.
   task automatic send_random_beat();
      logic [31:0] d;
      int          p;
      d = $urandom();
      p = $urandom_range(99);
      if (p < 2) begin
         deep_scan = ($urandom_range(3) == 0);
         send_beat(OP_START, d);
         return;
      end
      case (sb.phase)
         WK_IDLE: begin
            // mostly start a scan; stray data here is simply dropped
            if (p < 85) begin
               deep_scan = ($urandom_range(3) == 0);
               send_beat(OP_START, d);
            end else begin
               send_beat(OP_DATA, d);
            end
            return;
         end
         WK_HOST_VID: if (p < 50) d[15:0] = VID_NONE;
         WK_BUS_VID:  if (p < (deep_scan ? 30 : 80)) d[15:0] = VID_NONE;
         WK_FUNC_VID: if (p < 65) d[15:0] = VID_NONE;
         WK_CLASS:
            if (p < (deep_scan ? 90 : 20)) d[31:16] = {CLASS_BRIDGE, SUB_PCI_PCI};
         default: ;
      endcase
      if (p >= 98 && p < 99) d[0] = ~d[0];
      send_beat(OP_DATA, d);
   endtask

   initial begin
      int i;
      int phase_idx;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      deep_scan = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: stray data while idle, multi-function host, bridge to bus 0xff,
      // restart in the middle of a scan, all-ones and all-zeros data.
      send_beat(OP_DATA, 32'hffffffff);
      send_beat(OP_START, 32'h0);
      send_beat(OP_DATA, 32'h0080ffff);   // host header: multi-function
      send_beat(OP_DATA, 32'hffffffff);   // host fn 0 absent
      send_beat(OP_DATA, 32'h00001234);   // host fn 1 present -> bus 1
      send_beat(OP_DATA, 32'h80861234);   // slot 0 vendor
      send_beat(OP_DATA, 32'h06040000);   // class: PCI-PCI bridge
      send_beat(OP_DATA, 32'h00810000);   // header, multi-function
      send_beat(OP_DATA, 32'h00ffff00);   // secondary bus 0xff
      send_beat(OP_DATA, 32'h00000000);   // vendor 0 on bus 0xff
      send_beat(OP_START, 32'hffffffff);  // abandon the running walk
      send_beat(OP_DATA, 32'h00000000);   // host single-function -> bus 0
      send_beat(OP_DATA, 32'h0000abcd);
      send_beat(OP_DATA, 32'hffffffff);   // class ff/ff/ff
      send_beat(OP_DATA, 32'h00800000);   // header
      send_beat(OP_DATA, 32'h00800000);   // function 0 header again: multi
      for (i = 0; i < 7; i++) send_beat(OP_DATA, 32'hffffffff);
      send_beat(OP_DATA, 32'hffffffff);   // slot 1 absent

      for (phase_idx = 0; phase_idx < 3; phase_idx++) begin
         send_idle_pct = (phase_idx == 0) ? 25 : (phase_idx == 1) ? 77 : 0;
         recv_idle_pct = (phase_idx == 0) ? 77 : (phase_idx == 1) ? 25 : 0;
         for (i = 0; i < 310; i++) send_random_beat();
         // hold off until the block has drained
         req_ch.valid <= 1'b0;
         do @(posedge clock); while (sb.owed.size() != 0);
      end

      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Simulation FAILED");
      $finish;
   end
endmodule
